// ----- hdl/lef_pkg.sv -----
// Shared constants, register codes and types of the Laplacian edge filter.
package lef_pkg;

   // Line store geometry and frame limits.
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int ADDR_W     = $clog2(MAX_WIDTH);

   // Field and register widths.
   localparam int PIXEL_W   = 8;
   localparam int CFG_W     = 11;
   localparam int GAIN_W    = 4;
   localparam int CSR_IDX_W = 2;

   // Result queue sizing.
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OUTPUT_GAIN  = 2'd2;

   // Register reset values.
   localparam logic [CFG_W-1:0]  WIDTH_RESET  = 11'd512;
   localparam logic [CFG_W-1:0]  HEIGHT_RESET = 11'd512;
   localparam logic [GAIN_W-1:0] GAIN_RESET   = 4'd5;
   localparam logic [CFG_W-1:0]  SIZE_MIN     = 11'd2;

   localparam logic [PIXEL_W-1:0] PIXEL_MAX = 8'd255;

   typedef logic [PIXEL_W-1:0] pixel_type;
   typedef logic [CFG_W-1:0]   cfg_word_type;
   typedef logic [ADDR_W-1:0]  addr_type;
   typedef logic [GAIN_W-1:0]  gain_type;

   // One line store entry: the pixel two rows up and the pixel one row up.
   typedef struct packed {
      pixel_type above;
      pixel_type current;
   } line_word_type;

   // Border repeat selects and end of frame mark for one result.
   typedef struct packed {
      logic top;
      logic bottom;
      logic left;
      logic right;
      logic last;
   } border_type;

   // The five window taps the kernel looks at.
   typedef struct packed {
      pixel_type centre;
      pixel_type up;
      pixel_type down;
      pixel_type left;
      pixel_type right;
   } taps_type;

   typedef struct packed {
      logic      last;
      pixel_type edge_value;
   } result_type;

endpackage

// ----- hdl/lef_line_store.sv -----
// Line store memory holding the two previous rows, one read and one write port.
module lef_line_store (
   input  logic                   clock,
   input  logic                   rd_en,
   input  lef_pkg::addr_type      rd_addr,
   output lef_pkg::line_word_type rd_data_ff,
   input  logic                   wr_en,
   input  lef_pkg::addr_type      wr_addr,
   input  lef_pkg::line_word_type wr_data
);

   lef_pkg::line_word_type mem [lef_pkg::MAX_WIDTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // The read word holds until the next read so a result can wait on it.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

// ----- hdl/lef_kernel.sv -----
// Four-neighbour Laplacian with border repeat, gain and saturation, registered.
module lef_kernel (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  lef_pkg::taps_type    taps,
   input  lef_pkg::border_type  border,
   input  lef_pkg::gain_type    gain,
   output logic                 out_valid_ff,
   output lef_pkg::result_type  result_ff
);

   lef_pkg::pixel_type up, down, left, right;
   logic [lef_pkg::PIXEL_W+1:0]              sum4;
   logic [lef_pkg::PIXEL_W+1:0]              four_centre;
   logic [lef_pkg::PIXEL_W+1:0]              magnitude;
   logic [lef_pkg::PIXEL_W+lef_pkg::GAIN_W+1:0] product;
   lef_pkg::result_type                      result_in;

   always_comb begin
      // A missing neighbour at the frame border repeats the centre pixel.
      up    = border.top    ? taps.centre : taps.up;
      down  = border.bottom ? taps.centre : taps.down;
      left  = border.left   ? taps.centre : taps.left;
      right = border.right  ? taps.centre : taps.right;

      sum4 = 10'(up) + 10'(down) + 10'(left) + 10'(right);
      four_centre = {taps.centre, 2'b00};
      magnitude = (sum4 >= four_centre) ? (sum4 - four_centre) : (four_centre - sum4);
      product = magnitude * 14'(gain);

      result_in.last = border.last;
      result_in.edge_value = (product > 14'(lef_pkg::PIXEL_MAX)) ?
                             lef_pkg::PIXEL_MAX : product[lef_pkg::PIXEL_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

endmodule

// ----- hdl/lef_out_fifo.sv -----
// Result queue between the filter pipeline and the response channel.
module lef_out_fifo (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   input  lef_pkg::result_type             push_data,
   output logic                            out_valid,
   input  logic                            out_ready,
   output lef_pkg::result_type             out_data,
   output logic [lef_pkg::FIFO_CNT_W-1:0]  count_ff
);

   lef_pkg::result_type                    store [lef_pkg::FIFO_DEPTH];
   logic [lef_pkg::FIFO_PTR_W-1:0]         wr_ptr_ff, rd_ptr_ff;
   logic                                   pop;

   assign out_valid = (count_ff != '0);
   assign out_data  = store[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         store[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ----- hdl/laplacian_edge_filter_3x3.sv -----
// Each result comes from the request one row plus one pixel after its own pixel, which
// completes its neighbourhood; it passes stages B and C, the kernel and the result queue.
// Throughput: one request per cycle while req_tready is high, set by the line store ports.
// Reset clears counters, window, pipeline and result queue and loads 512, 512 and 5 into the
// registers; the line store is not cleared, the border repeat hides its unwritten entries.
module laplacian_edge_filter_3x3 (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] pixel_value
   input  logic        req_tuser,   // [0] mode: 0 pixel, 1 drain tick
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] edge_value
   output logic        rsp_tlast,   // last_of_frame
   // Configuration write port.
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_wdata
);

   // Configuration registers and their clamped working values.
   lef_pkg::cfg_word_type width_ff, height_ff;
   lef_pkg::gain_type     gain_ff;
   lef_pkg::cfg_word_type eff_width, eff_height;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= lef_pkg::WIDTH_RESET;
         height_ff <= lef_pkg::HEIGHT_RESET;
         gain_ff   <= lef_pkg::GAIN_RESET;
      end else if (csr_we) begin
         case (csr_index)
            lef_pkg::REG_IMAGE_WIDTH:  width_ff  <= csr_wdata;
            lef_pkg::REG_IMAGE_HEIGHT: height_ff <= csr_wdata;
            lef_pkg::REG_OUTPUT_GAIN:  gain_ff   <= csr_wdata[lef_pkg::GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (width_ff < lef_pkg::SIZE_MIN) begin
         eff_width = lef_pkg::SIZE_MIN;
      end else if (width_ff > lef_pkg::cfg_word_type'(lef_pkg::MAX_WIDTH)) begin
         eff_width = lef_pkg::cfg_word_type'(lef_pkg::MAX_WIDTH);
      end else begin
         eff_width = width_ff;
      end
      if (height_ff < lef_pkg::SIZE_MIN) begin
         eff_height = lef_pkg::SIZE_MIN;
      end else if (height_ff > lef_pkg::cfg_word_type'(lef_pkg::MAX_HEIGHT)) begin
         eff_height = lef_pkg::cfg_word_type'(lef_pkg::MAX_HEIGHT);
      end else begin
         eff_height = height_ff;
      end
   end

   // Stage A: request acceptance, raster position and border decisions.
   // The row counter runs past the last row into the drain phase, which lasts one
   // row plus one pixel and flushes the results still held in the line store.
   lef_pkg::addr_type     col_ff, col_in;
   lef_pkg::cfg_word_type row_ff, row_in;
   lef_pkg::cfg_word_type col_ext, out_row;
   logic                  drain, skip, accept, proceed, final_item, emit;
   lef_pkg::border_type   border;

   assign accept  = req_tvalid && req_tready;
   assign drain   = (row_ff >= eff_height);
   // A drain tick while pixels are still expected is dropped without effect.
   assign skip    = !drain && req_tuser;
   assign proceed = accept && !skip;
   assign col_ext = lef_pkg::cfg_word_type'(col_ff);

   always_comb begin
      final_item = drain && (row_ff > eff_height);
      emit = (row_ff >= 11'd2) || ((row_ff == 11'd1) && (col_ff != '0));

      // The result leaving now belongs to the previous column, or to the last
      // column of the row before when the position has just wrapped.
      if (col_ff != '0) begin
         out_row = row_ff - 11'd1;
      end else if (row_ff >= 11'd2) begin
         out_row = row_ff - 11'd2;
      end else begin
         out_row = '0;
      end
      border.top    = (out_row == '0);
      border.bottom = (out_row >= eff_height - 11'd1);
      border.left   = (col_ff == lef_pkg::addr_type'(1));
      border.right  = (col_ff == '0) || (col_ext >= eff_width);
      border.last   = final_item;

      col_in = col_ff;
      row_in = row_ff;
      if (final_item) begin
         col_in = '0;
         row_in = '0;
      end else if (col_ext + 11'd1 >= eff_width) begin
         col_in = '0;
         row_in = row_ff + 11'd1;
      end else begin
         col_in = col_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (proceed) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Stage B: the line store word for this column arrives; the window shifts and the
   // column is written back with the rows moved up by one.
   logic                   b_valid_ff, b_drain_ff, b_emit_ff;
   lef_pkg::pixel_type     b_pixel_ff;
   lef_pkg::addr_type      b_addr_ff;
   lef_pkg::border_type    b_border_ff;
   lef_pkg::line_word_type line_rd, line_wr;
   logic                   line_we;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= proceed;
      end
   end

   always_ff @(posedge clock) begin
      b_drain_ff  <= drain;
      b_emit_ff   <= emit;
      b_pixel_ff  <= req_tdata;
      b_addr_ff   <= col_ff;
      b_border_ff <= border;
   end

   assign line_we         = b_valid_ff && !b_drain_ff;
   assign line_wr.above   = line_rd.current;
   assign line_wr.current = b_pixel_ff;

   lef_line_store u_line_store (
      .clock      (clock),
      .rd_en      (proceed),
      .rd_addr    (col_ff),
      .rd_data_ff (line_rd),
      .wr_en      (line_we),
      .wr_addr    (b_addr_ff),
      .wr_data    (line_wr)
   );

   // Window columns 0..2 run from oldest to newest; only the taps the kernel reads
   // are kept. Drain ticks shift zero into the bottom row.
   lef_pkg::pixel_type win_top1_ff, win_top2_ff;
   lef_pkg::pixel_type win_mid0_ff, win_mid1_ff, win_mid2_ff;
   lef_pkg::pixel_type win_bot1_ff, win_bot2_ff;
   lef_pkg::pixel_type bot_in;

   assign bot_in = b_drain_ff ? '0 : b_pixel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_top1_ff <= '0;
         win_top2_ff <= '0;
         win_mid0_ff <= '0;
         win_mid1_ff <= '0;
         win_mid2_ff <= '0;
         win_bot1_ff <= '0;
         win_bot2_ff <= '0;
      end else if (b_valid_ff) begin
         win_top1_ff <= win_top2_ff;
         win_top2_ff <= line_rd.above;
         win_mid0_ff <= win_mid1_ff;
         win_mid1_ff <= win_mid2_ff;
         win_mid2_ff <= line_rd.current;
         win_bot1_ff <= win_bot2_ff;
         win_bot2_ff <= bot_in;
      end
   end

   // Stage C: the window now holds this request's neighbourhood.
   logic                c_valid_ff;
   lef_pkg::border_type c_border_ff;
   lef_pkg::taps_type   taps;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= b_valid_ff && b_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      c_border_ff <= b_border_ff;
   end

   assign taps.centre = win_mid1_ff;
   assign taps.up     = win_top1_ff;
   assign taps.down   = win_bot1_ff;
   assign taps.left   = win_mid0_ff;
   assign taps.right  = win_mid2_ff;

   logic                k_valid;
   lef_pkg::result_type k_result;

   lef_kernel u_kernel (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (c_valid_ff),
      .taps         (taps),
      .border       (c_border_ff),
      .gain         (gain_ff),
      .out_valid_ff (k_valid),
      .result_ff    (k_result)
   );

   // The result queue lets requests keep flowing while the response side stalls.
   // A request is taken only when every result in flight is sure of a queue slot.
   lef_pkg::result_type                 rsp_item;
   logic [lef_pkg::FIFO_CNT_W-1:0]      fifo_count;
   logic [lef_pkg::FIFO_CNT_W:0]        credit_sum;

   lef_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (k_valid),
      .push_data (k_result),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_item),
      .count_ff  (fifo_count)
   );

   assign credit_sum = (lef_pkg::FIFO_CNT_W+1)'(fifo_count)
                     + (lef_pkg::FIFO_CNT_W+1)'(b_valid_ff)
                     + (lef_pkg::FIFO_CNT_W+1)'(c_valid_ff)
                     + (lef_pkg::FIFO_CNT_W+1)'(k_valid);
   assign req_tready = (credit_sum < (lef_pkg::FIFO_CNT_W+1)'(lef_pkg::FIFO_DEPTH));

   assign rsp_tdata = rsp_item.edge_value;
   assign rsp_tlast = rsp_item.last;

`ifndef SYNTHESIS
   // Consecutive requests always sit in different columns, so the write-back of one
   // column never meets the read of the next.
   a_no_line_collision: assert property (@(posedge clock) disable iff (reset)
      (proceed && line_we) |-> (col_ff != b_addr_ff))
      else $error("line store read and write hit the same column");

   // Results in flight never outnumber the free queue slots.
   a_queue_credit: assert property (@(posedge clock) disable iff (reset)
      credit_sum <= (lef_pkg::FIFO_CNT_W+1)'(lef_pkg::FIFO_DEPTH))
      else $error("result queue credit exceeded");

   // The final drain request returns the raster position to the frame origin.
   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      (proceed && final_item) |=> ((row_ff == '0) && (col_ff == '0)))
      else $error("position did not return to origin after the frame");
`endif

endmodule
